FILE: hw/rtl/sha1_pkg.sv
// Package with shared types and constants of the SHA-1 engine.
`timescale 1ns / 1ps
package sha1_pkg;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;
	localparam logic [60:0] BYTE_COUNT_MAX = {61{1'b1}};
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [159:0] INIT_CHAIN =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	// One classified transaction handed from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
	} sha1_cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} sha1_qstat_t;
endpackage

FILE: hw/rtl/sha1_front.sv
// Front end: accepts input transactions, drops empty non-final ones, queues the rest.
`timescale 1ns / 1ps
module sha1_front
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        pop,
	output sha1_cmd_t   head,
	output sha1_qstat_t qstat
);
	sha1_cmd_t         mem_q [QDEPTH];
	logic [QAW-1:0]    wp_q, rp_q;
	logic [QAW:0]      cnt_q;
	logic              push;

	assign qstat.full  = (cnt_q == QDEPTH[QAW:0]);
	assign qstat.empty = (cnt_q == '0);
	assign in_stall    = qstat.full;
	// Only transactions that carry a byte or end the message do any work.
	assign push = in_valid && !qstat.full && (byte_valid || last);
	assign head = mem_q[rp_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{data: data_byte, valid: byte_valid, last: last};
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + QAW'(1);
			if (pop) rp_q <= rp_q + QAW'(1);
			cnt_q <= cnt_q + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QDEPTH[QAW:0]) else $error("queue count overflow");
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push) else $error("push into full queue");
`endif
endmodule

FILE: hw/rtl/sha1_back.sv
// Back end: block buffer, padding, 80-round compression and digest output.
`timescale 1ns / 1ps
module sha1_back
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sha1_cmd_t   head,
	input  sha1_qstat_t qstat,
	output logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        out_valid,
	input  logic        out_stall
);
	typedef enum logic [2:0] {S_TAKE, S_PUT, S_ROUND, S_FOLD, S_PAD, S_OUT} state_t;

	state_t        state_q;
	logic [31:0]   w_q [16];
	logic [31:0]   h_q [5];
	logic [31:0]   a_q, b_q, c_q, d_q, e_q;
	logic [60:0]   cnt_q;
	logic [6:0]    rnd_q;
	logic [5:0]    fill_q;
	logic [7:0]    byte_q;
	logic          pad_q;
	logic [3:0]    len_q;
	logic          lastc_q;
	logic [2:0]    oidx_q;
	logic [63:0]   bits;
	logic [31:0]   wt, wn, f, k, tmp;
	logic [3:0]    ri;

	assign bits = {cnt_q, 3'b000};
	assign ri = rnd_q[3:0];
	assign pop = (state_q == S_TAKE) && !qstat.empty;
	assign out_valid = (state_q == S_OUT);
	assign digest_word = h_q[0];
	assign word_index = oidx_q;
	assign last_word = (oidx_q == 3'd4);

	// Schedule word and round function.
	always_comb begin
		wn = w_q[ri - 4'd3] ^ w_q[ri - 4'd8] ^ w_q[ri - 4'd14] ^ w_q[ri];
		wn = {wn[30:0], wn[31]};
		wt = (rnd_q < 7'd16) ? w_q[ri] : wn;
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = K3;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
	end

	// Sequencer with buffer, counters and digest rotation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
			for (int i = 0; i < 5; i++) h_q[i] <= INIT_CHAIN[159-32*i -: 32];
			cnt_q <= '0; rnd_q <= '0; fill_q <= '0; pad_q <= 1'b0;
			len_q <= '0; lastc_q <= 1'b0; oidx_q <= '0; byte_q <= '0;
		end else begin
			case (state_q)
				S_TAKE: begin
					if (!qstat.empty) begin
						lastc_q <= head.last;
						pad_q <= 1'b0;
						len_q <= '0;
						if (head.valid) begin
							byte_q <= head.data;
							if (cnt_q != BYTE_COUNT_MAX) cnt_q <= cnt_q + 61'd1;
							state_q <= S_PUT;
						end else begin
							state_q <= S_PAD;
						end
					end
				end
				S_PUT: begin
					if (fill_q[1:0] == 2'd0)
						w_q[fill_q[5:2]] <= {byte_q, 24'd0};
					else
						w_q[fill_q[5:2]] <= w_q[fill_q[5:2]] |
							({24'd0, byte_q} << (6'd24 - {1'b0, fill_q[1:0], 3'b000}));
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
						d_q <= h_q[3]; e_q <= h_q[4]; rnd_q <= '0;
						state_q <= S_ROUND;
					end else if (lastc_q) state_q <= S_PAD;
					else state_q <= S_TAKE;
				end
				S_ROUND: begin
					if (rnd_q >= 7'd16) w_q[ri] <= wn;
					e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]};
					b_q <= a_q; a_q <= tmp;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= S_FOLD;
				end
				S_FOLD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q; rnd_q <= '0;
					if (lastc_q && len_q == 4'd8) begin
						oidx_q <= '0; state_q <= S_OUT;
					end else if (lastc_q) state_q <= S_PAD;
					else state_q <= S_TAKE;
				end
				S_PAD: begin
					// Marker byte, zero fill, then eight length bytes.
					if (!pad_q) begin
						byte_q <= PAD_BYTE; pad_q <= 1'b1; state_q <= S_PUT;
					end else if (len_q == 4'd8) begin
						oidx_q <= '0; state_q <= S_OUT;
					end else if (fill_q != LEN_POS && len_q == 4'd0) begin
						byte_q <= '0; state_q <= S_PUT;
					end else begin
						byte_q <= bits[63 - 8*len_q[2:0] -: 8];
						len_q <= len_q + 4'd1; state_q <= S_PUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						for (int i = 0; i < 4; i++) h_q[i] <= h_q[i+1];
						h_q[4] <= INIT_CHAIN[159-32*oidx_q -: 32];
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd4) begin
							cnt_q <= '0; fill_q <= '0; lastc_q <= 1'b0;
							state_q <= S_TAKE;
						end
					end
				end
				default: state_q <= S_TAKE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(oidx_q))
		else $error("digest output moved while stalled");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> oidx_q <= 3'd4) else $error("bad word index");
	a_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUND |-> rnd_q < 7'd80) else $error("round overrun");
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_q == 6'd0) else $error("digest with partial block");
`endif
endmodule

FILE: hw/rtl/sha1_hash_engine_unit.sv
// Top level of the SHA-1 engine: front queue and compression back end.
//  channel | direction | signals
//  in      | input     | in_valid, in_stall, data_byte, byte_valid, last
//  out     | output    | out_valid, out_stall, digest_word, word_index, last_word
// Each message byte is taken from the queue, then stored, by the back sequencer,
// and every full 64-byte block then runs the 80 rounds and the chaining fold.
// A final transaction adds padding (one or two blocks) and five digest output words.
// Reset restores the initial chaining value; the block buffer is not cleared.
// The front queue of four entries absorbs input while the back end compresses.
`timescale 1ns / 1ps
module sha1_hash_engine_unit
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	sha1_cmd_t   head;
	sha1_qstat_t qstat;
	logic        pop;

	sha1_front u_front (.clk, .arst_n, .data_byte, .byte_valid, .last, .in_valid,
		.in_stall, .pop, .head, .qstat);
	sha1_back u_back (.clk, .arst_n, .head, .qstat, .pop, .digest_word,
		.word_index, .last_word, .out_valid, .out_stall);
endmodule

FILE: tb/sv/sha1_hash_engine_unit_tb.sv
// Self-checking testbench for the SHA-1 engine: directed table, then random messages.
`timescale 1ns / 1ps
module sha1_hash_engine_unit_tb;
	import sha1_pkg::*;

	localparam int ITEM_TARGET = 460;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_CYCLES = 700;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// One expected digest word.
	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        lastw;
	} digest_exp_t;

	// One row of the directed table; a nonzero has_digest means the digest is typed in.
	typedef struct {
		logic [7:0]   data;
		logic         bv;
		logic         lst;
		bit           has_digest;
		logic [159:0] digest;
	} dir_row_t;

	digest_exp_t digest_q[$];
	int errors;
	int cycles;
	int items_sent;
	int digests_seen;
	int messages_sent;
	bit quiet;
	bit hold_on;
	bit hold_go;
	logic rx_stall;
	int rx_wait;

	// Shadow SHA-1 state.
	logic [31:0] sh_block [16];
	logic [31:0] sh_chain [5];
	logic [60:0] sh_count;
	logic [5:0]  sh_fill;

	sha1_hash_engine_unit dut (.*);

	// Clock, 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// Run the 80 rounds over the block buffer and fold into the chain.
	task automatic sha1_compress();
		logic [31:0] a, b, c, d, e, f, k, w, t;
		a = sh_chain[0]; b = sh_chain[1]; c = sh_chain[2];
		d = sh_chain[3]; e = sh_chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16) begin
				w = sh_block[(r - 3) & 15] ^ sh_block[(r - 8) & 15] ^
					sh_block[(r - 14) & 15] ^ sh_block[r & 15];
				sh_block[r & 15] = rotl(w, 1);
			end
			w = sh_block[r & 15];
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			t = rotl(a, 5) + f + e + k + w;
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		sh_chain[0] += a; sh_chain[1] += b; sh_chain[2] += c;
		sh_chain[3] += d; sh_chain[4] += e;
	endtask

	// Pack one byte big-endian into the buffer; compress on a full block.
	task automatic sha1_put(input logic [7:0] bt);
		int lane;
		lane = sh_fill[1:0];
		if (lane == 0)
			sh_block[sh_fill[5:2]] = {bt, 24'h0};
		else
			sh_block[sh_fill[5:2]] |= 32'(bt) << (24 - 8 * lane);
		sh_fill = sh_fill + 6'd1;
		if (sh_fill == 6'd0)
			sha1_compress();
	endtask

	task automatic sha1_reset();
		for (int i = 0; i < 5; i++)
			sh_chain[i] = INIT_CHAIN[159 - 32 * i -: 32];
		sh_count = '0;
		sh_fill = '0;
	endtask

	// Advance the shadow state by one transaction; returns the digest on a final one.
	task automatic sha1_absorb(input logic [7:0] d, input logic bv, input logic lst,
			output logic [159:0] dig);
		logic [63:0] bits;
		dig = '0;
		if (bv) begin
			sha1_put(d);
			if (sh_count != BYTE_COUNT_MAX)
				sh_count = sh_count + 61'd1;
		end
		if (lst) begin
			bits = {sh_count, 3'b000};
			sha1_put(PAD_BYTE);
			while (sh_fill != LEN_POS)
				sha1_put(8'h00);
			for (int i = 7; i >= 0; i--)
				sha1_put(bits[8 * i +: 8]);
			dig = {sh_chain[0], sh_chain[1], sh_chain[2], sh_chain[3], sh_chain[4]};
			sha1_reset();
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("ERROR at cycle %0d: %s got %h expected %h", cycles, what, got, want);
	endtask

	// Offer one transaction, hold it through stalls, and queue its digest words.
	task automatic send_item(input logic [7:0] d, input logic bv, input logic lst,
			input bit typed, input logic [159:0] typed_dig);
		int gap;
		logic [159:0] dig;
		digest_exp_t ent;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		byte_valid <= bv;
		last <= lst;
		do
			@(posedge clk);
		while (in_stall);
		sha1_absorb(d, bv, lst, dig);
		if (lst) begin
			if (typed)
				dig = typed_dig;
			for (int i = 0; i < 5; i++) begin
				ent.word = dig[159 - 32 * i -: 32];
				ent.idx = 3'(i);
				ent.lastw = (i == 4);
				digest_q.insert(digest_q.size(), ent);
			end
			messages_sent++;
		end
		@(negedge clk);
	endtask

	// Receiver stall: per-word random wait, plus the long hold.
	assign out_stall = rx_stall | hold_on;

	always @(negedge clk) begin
		if (rx_wait > 0) begin
			rx_stall <= 1'b1;
			rx_wait = rx_wait - 1;
		end else begin
			rx_stall <= 1'b0;
		end
	end

	// Long hold-off, counted here so the sender keeps going and the front fills.
	initial begin
		hold_on = 1'b0;
		wait (hold_go);
		@(negedge clk);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_on = 1'b0;
	end

	// Result checker.
	always @(posedge clk) begin
		digest_exp_t x;
		if (arst_n && out_valid && !out_stall) begin
			digests_seen++;
			rx_wait = quiet ? 0 : $urandom_range(0, 15);
			if (digest_q.size() == 0) begin
				errors++;
				$display("ERROR at cycle %0d: digest word %h with nothing expected",
					cycles, digest_word);
			end else begin
				x = digest_q.pop_front();
				if (digest_word !== x.word)
					report("digest_word", digest_word, x.word);
				if (word_index !== x.idx)
					report("word_index", 32'(word_index), 32'(x.idx));
				if (last_word !== x.lastw)
					report("last_word", 32'(last_word), 32'(x.lastw));
			end
		end
	end

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d digest words outstanding",
				cycles, digest_q.size());
			$display("sha1_hash_engine_unit: mismatch");
			$finish;
		end
	end

	// Directed table: empty and "abc" digests are the standard known answers.
	dir_row_t dir_rows[] = '{
		'{8'h00, 1'b0, 1'b1, 1, 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709},
		'{8'h61, 1'b1, 1'b0, 0, '0},
		'{8'h62, 1'b1, 1'b0, 0, '0},
		'{8'h63, 1'b1, 1'b1, 1, 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d},
		'{8'hff, 1'b1, 1'b0, 0, '0},
		'{8'h5a, 1'b0, 1'b0, 0, '0},
		'{8'h00, 1'b1, 1'b0, 0, '0},
		'{8'hff, 1'b0, 1'b1, 0, '0},
		'{8'h00, 1'b1, 1'b1, 0, '0},
		'{8'hff, 1'b1, 1'b1, 0, '0},
		'{8'ha5, 1'b0, 1'b0, 0, '0},
		'{8'h00, 1'b0, 1'b1, 1, 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709}
	};

	initial begin
		int len;
		int boundary_lens[4];
		logic [7:0] bt;
		boundary_lens[0] = 55; boundary_lens[1] = 56;
		boundary_lens[2] = 63; boundary_lens[3] = 64;
		errors = 0; cycles = 0; items_sent = 0; digests_seen = 0; messages_sent = 0;
		quiet = 0; hold_go = 0; rx_wait = 0; rx_stall = 1'b0;
		in_valid = 1'b0; data_byte = 8'h00; byte_valid = 1'b0; last = 1'b0;
		sha1_reset();
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].data, dir_rows[i].bv, dir_rows[i].lst,
				dir_rows[i].has_digest, dir_rows[i].digest);
			items_sent++;
		end

		// Random messages; the first few sit on the padding boundaries.
		for (int m = 0; items_sent < ITEM_TARGET; m++) begin
			if (m < 4)
				len = boundary_lens[m];
			else if ($urandom_range(0, 19) == 0)
				len = $urandom_range(50, 130);
			else
				len = $urandom_range(0, 40);
			quiet = ($urandom_range(0, 3) == 0);
			if (m == 6)
				hold_go = 1;
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(0, 7) == 0) begin
					send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 0, '0);
					items_sent++;
				end
				bt = 8'($urandom_range(0, 255));
				if (j == len - 1 && $urandom_range(0, 1)) begin
					send_item(bt, 1'b1, 1'b1, 0, '0);
					len = -1;
				end else begin
					send_item(bt, 1'b1, 1'b0, 0, '0);
				end
				items_sent++;
			end
			if (len >= 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 0, '0);
				items_sent++;
			end
		end
		in_valid <= 1'b0;
		quiet = 0;

		// Drain the outstanding digests, then let the engine settle.
		while (digest_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Ran %0d transactions over %0d messages, including padding boundaries,",
			items_sent, messages_sent);
		$display("empty finals, ignored bytes and a long output hold; %0d words checked.",
			digests_seen);
		if (errors == 0)
			$display("sha1_hash_engine_unit: match");
		else
			$display("sha1_hash_engine_unit: mismatch");
		$finish;
	end
endmodule

FILE: sha1_hash_engine_unit.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_front.sv
hw/rtl/sha1_back.sv
hw/rtl/sha1_hash_engine_unit.sv
tb/sv/sha1_hash_engine_unit_tb.sv
